/* hw/rtl/jset_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Julia-set escape-time package
// Shared widths, constants, codes and control/status types.
// ----------------------------------------------------------------------------
package jset_pkg;

    localparam int IDX_W   = 10;                 // pixel index width
    localparam int FRAC_W  = 28;                 // Q4.28 fraction bits
    localparam int Q_W     = 32;                 // Q4.28 word
    localparam int CNT_W   = 8;                  // iteration count / limit
    localparam int COL_W   = 8;                  // colour channel
    localparam int LVL_W   = 16;                 // count * 255
    localparam int DVD_W   = IDX_W + FRAC_W + 1; // index << 29
    localparam int SQ_W    = 2 * Q_W - FRAC_W;   // truncated product

    localparam int WIDTH_DEF  = 800;
    localparam int HEIGHT_DEF = 600;

    localparam logic signed [Q_W-1:0] C_REAL_RST = -32'sd212788786;
    localparam logic signed [Q_W-1:0] C_IMAG_RST = 32'sd43191265;
    localparam logic [CNT_W-1:0]      LIMIT_RST  = 8'd150;

    localparam logic [COL_W-1:0] GREY_LEVEL = 8'd180;
    localparam logic [LVL_W-1:0] FULL_LEVEL = 16'd255;

    typedef enum logic [1:0] {
        REG_C_REAL = 2'd0,
        REG_C_IMAG = 2'd1,
        REG_LIMIT  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic load_in;
        logic map_idx;
        logic load_z;
        logic div_start;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic go_on;     // count below limit and not escaped
        logic need_div;  // escaped with a nonzero limit
    } sts_t;

    // x / 10 for x < 256
    function automatic logic [COL_W-1:0] div10(input logic [COL_W-1:0] x);
        logic [18:0] p;
        p = 19'(x) * 19'd205;
        return p[18:11];
    endfunction

endpackage

/* hw/rtl/jset_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jset_div #(
    parameter int N = 39,
    parameter int D = 13
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic [N-1:0] quotient,
    output logic         done
);
    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  dvd_reg, dvd_next;
    logic [D-1:0]  dsr_reg, dsr_next;
    logic [D-1:0]  rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [D:0]    rem_sh;
    logic [D:0]    rem_sub;
    logic          ge;

    assign rem_sh  = {rem_reg, dvd_reg[N-1]};
    assign ge      = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[N-2:0], ge};
            rem_next = ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

/* hw/rtl/jset_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Julia-set datapath
// Config registers, coordinate mapping, z iteration, colour and result item.
// ----------------------------------------------------------------------------
module jset_dp #(
    parameter int WIDTH  = jset_pkg::WIDTH_DEF,
    parameter int HEIGHT = jset_pkg::HEIGHT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [jset_pkg::IDX_W-1:0]  horizontal_index,
    input  logic [jset_pkg::IDX_W-1:0]  vertical_index,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [31:0]                 cfg_data,
    input  jset_pkg::cmd_t              cmd,
    output jset_pkg::sts_t              sts,
    output logic [jset_pkg::COL_W-1:0]  blue,
    output logic [jset_pkg::COL_W-1:0]  green,
    output logic [jset_pkg::COL_W-1:0]  red,
    output logic [jset_pkg::CNT_W-1:0]  iteration_count,
    output logic                        inside_set
);
    import jset_pkg::*;

    localparam logic signed [36:0] ESCAPE_Q = 37'sd1 <<< (FRAC_W + 2);
    localparam logic signed [39:0] ONE_Q    = 40'sd1 <<< FRAC_W;

    // floor(idx * 2^29 / size) as idx * ceil(2^k / size) >> (k - 29),
    // exact for every 10-bit index when k = 39 + clog2(size)
    localparam int RCP_W = DVD_W + 1;
    localparam int LH    = $clog2(HEIGHT);
    localparam int LW    = $clog2(WIDTH);
    localparam logic [63:0] RCP_H64 =
        ((64'd1 << (DVD_W + LH)) + 64'(HEIGHT) - 64'd1) / 64'(HEIGHT);
    localparam logic [63:0] RCP_W64 =
        ((64'd1 << (DVD_W + LW)) + 64'(WIDTH) - 64'd1) / 64'(WIDTH);
    localparam logic [RCP_W-1:0] RCP_H = RCP_H64[RCP_W-1:0];
    localparam logic [RCP_W-1:0] RCP_WD = RCP_W64[RCP_W-1:0];

    logic [IDX_W-1:0]         h_reg, v_reg;
    logic [DVD_W-1:0]         qr_reg, qi_reg;
    logic signed [Q_W-1:0]    c_real_reg, c_imag_reg;
    logic [CNT_W-1:0]         limit_reg;
    logic signed [Q_W-1:0]    zr_reg, zi_reg;
    logic signed [SQ_W-1:0]   rr_reg, ii_reg, ri_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [COL_W-1:0]         blue_reg, green_reg, red_reg, cnt_out_reg;
    logic                     inside_reg;

    logic [IDX_W+RCP_W-1:0]   prod_v, prod_h;
    logic signed [2*Q_W-1:0]  p_rr, p_ii, p_ri;
    logic signed [36:0]       norm;
    logic                     escaped;
    logic                     stay_in;
    logic signed [39:0]       nr_wide, ni_wide, map_re, map_im;
    logic [LVL_W-1:0]         quo;
    logic                     div_done;
    logic [LVL_W-1:0]         cnt255;
    logic [COL_W-1:0]         level;

    function automatic logic signed [Q_W-1:0] sat40(input logic signed [39:0] v);
        if (v[39:Q_W-1] == '0 || v[39:Q_W-1] == '1)
            return v[Q_W-1:0];
        else if (v[39])
            return {1'b1, {(Q_W-1){1'b0}}};
        else
            return {1'b0, {(Q_W-1){1'b1}}};
    endfunction

    assign prod_v = v_reg * RCP_H;
    assign prod_h = h_reg * RCP_WD;

    assign map_re = $signed({1'b0, qr_reg}) - ONE_Q;
    assign map_im = $signed({1'b0, qi_reg}) - ONE_Q;

    jset_div #(
        .N (LVL_W),
        .D (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cnt255),
        .divisor  (limit_reg),
        .quotient (quo),
        .done     (div_done)
    );

    // products of the current z; registered before the add
    assign p_rr = zr_reg * zr_reg;
    assign p_ii = zi_reg * zi_reg;
    assign p_ri = zr_reg * zi_reg;

    assign norm    = {rr_reg[SQ_W-1], rr_reg} + {ii_reg[SQ_W-1], ii_reg};
    assign escaped = norm >= ESCAPE_Q;
    assign nr_wide = {{(40-SQ_W){rr_reg[SQ_W-1]}}, rr_reg}
                   - {{(40-SQ_W){ii_reg[SQ_W-1]}}, ii_reg}
                   + {{(40-Q_W){c_real_reg[Q_W-1]}}, c_real_reg};
    assign ni_wide = {{(39-SQ_W){ri_reg[SQ_W-1]}}, ri_reg, 1'b0}
                   + {{(40-Q_W){c_imag_reg[Q_W-1]}}, c_imag_reg};

    assign stay_in  = (count_reg == limit_reg) && !escaped;
    assign cnt255   = LVL_W'(count_reg) * FULL_LEVEL;
    assign level    = quo[COL_W-1:0];

    assign sts.div_done = div_done;
    assign sts.go_on    = (count_reg < limit_reg) && !escaped;
    assign sts.need_div = !stay_in && (limit_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_real_reg <= C_REAL_RST;
            c_imag_reg <= C_IMAG_RST;
            limit_reg  <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_C_REAL: c_real_reg <= cfg_data;
                REG_C_IMAG: c_imag_reg <= cfg_data;
                REG_LIMIT:  limit_reg  <= cfg_data[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rr_reg <= p_rr[2*Q_W-1:FRAC_W];
        ii_reg <= p_ii[2*Q_W-1:FRAC_W];
        ri_reg <= p_ri[2*Q_W-1:FRAC_W];
        if (cmd.load_in)
        begin
            h_reg     <= horizontal_index;
            v_reg     <= vertical_index;
            count_reg <= '0;
        end
        if (cmd.map_idx)
        begin
            qr_reg <= DVD_W'(prod_v >> (IDX_W + LH));
            qi_reg <= DVD_W'(prod_h >> (IDX_W + LW));
        end
        if (cmd.load_z)
        begin
            zr_reg <= sat40(map_re);
            zi_reg <= sat40(map_im);
        end
        if (cmd.step)
        begin
            zr_reg    <= sat40(nr_wide);
            zi_reg    <= sat40(ni_wide);
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            cnt_out_reg <= count_reg;
            inside_reg  <= stay_in;
            if (stay_in)
            begin
                blue_reg  <= GREY_LEVEL;
                green_reg <= GREY_LEVEL;
                red_reg   <= GREY_LEVEL;
            end
            else if (limit_reg == '0)
            begin
                blue_reg  <= '0;
                green_reg <= '0;
                red_reg   <= '0;
            end
            else
            begin
                blue_reg  <= div10(level);
                green_reg <= div10(level);
                red_reg   <= level;
            end
        end
    end

    assign blue            = blue_reg;
    assign green           = green_reg;
    assign red             = red_reg;
    assign iteration_count = cnt_out_reg;
    assign inside_set      = inside_reg;

endmodule

/* hw/rtl/jset_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Julia-set controller
// Sequences mapping, iteration, colour division and the result handshake.
// ----------------------------------------------------------------------------
module jset_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  jset_pkg::sts_t sts,
    output jset_pkg::cmd_t cmd
);
    import jset_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP,
        S_LOAD,
        S_SQ,
        S_TEST,
        S_LVL_WAIT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MAP;
                end
            end
            S_MAP:
            begin
                cmd.map_idx = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_z = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (sts.go_on)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_SQ;
                end
                else if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_LVL_WAIT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_LVL_WAIT:
            begin
                if (sts.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/julia_set_escape_time_pixel.sv */
`timescale 1ns / 1ps
// Flow: an accepted item passes mapping and z load, then the square-and-add loop
//   (S_SQ, S_TEST) per iteration, then the serial colour division, which runs
//   unless the point stays inside or the limit is zero.
// Accept: next item taken in the cycle after the result loads, also while it waits.
// Reset: rst_n clears control and loads the default constant and limit.
// ----------------------------------------------------------------------------
// Julia-set escape-time pixel
// Maps a pixel to z0, iterates z = z*z + c and returns its colour.
// ----------------------------------------------------------------------------
module julia_set_escape_time_pixel #(
    parameter int WIDTH  = jset_pkg::WIDTH_DEF,
    parameter int HEIGHT = jset_pkg::HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // horizontal_index[9:0], vertical_index[19:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // blue[7:0], green[15:8], red[23:16],
                                   // iteration_count[31:24]
    output logic [0:0]  m_tuser,   // inside_set[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import jset_pkg::*;

    cmd_t             cmd;
    sts_t             sts;
    logic [COL_W-1:0] blue, green, red;
    logic [CNT_W-1:0] iteration_count;
    logic             inside_set;

    assign cfg_ready = 1'b1;

    jset_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    jset_dp #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .horizontal_index (s_tdata[9:0]),
        .vertical_index   (s_tdata[19:10]),
        .cfg_we           (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .sts              (sts),
        .blue             (blue),
        .green            (green),
        .red              (red),
        .iteration_count  (iteration_count),
        .inside_set       (inside_set)
    );

    assign m_tdata = {iteration_count, red, green, blue};
    assign m_tuser = inside_set;

endmodule

/* hw/rtl/jset_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Julia-set port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module jset_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while another is in work");

    a_inside_grey: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'd180 &&
        m_tdata[15:8] == 8'd180 && m_tdata[23:16] == 8'd180)
        else $error("inside point not grey");

    a_outside_colour: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == m_tdata[15:8] &&
        m_tdata[7:0] <= m_tdata[23:16])
        else $error("escaped point colour channels inconsistent");

endmodule

bind julia_set_escape_time_pixel jset_chk u_chk (.*);
